// ===== sv/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// brc_pkg: shared types and constants for the bytewise reflected crc
// Word layouts, width mode codes, polynomials and masks.
// ----------------------------------------------------------------------------
package brc_pkg;

  localparam int CrcW = 32;

  // width mode codes
  localparam logic [1:0] WIDTH_32 = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_5  = 2'd2;

  localparam logic [CrcW-1:0] POLY_W32 = 32'hEDB8_8320;
  localparam logic [CrcW-1:0] POLY_W16 = 32'h0000_1021;
  localparam logic [CrcW-1:0] POLY_W5  = 32'h0000_0005;
  localparam logic [CrcW-1:0] MASK_W32 = 32'hFFFF_FFFF;
  localparam logic [CrcW-1:0] MASK_W16 = 32'h0000_FFFF;
  localparam logic [CrcW-1:0] MASK_W5  = 32'h0000_001F;

  typedef struct packed {
    logic [7:0]      data_byte;
    logic            last_byte;
    logic [CrcW-1:0] expected_crc;
  } in_word_t;

  typedef struct packed {
    logic [CrcW-1:0] crc_value;
    logic            crc_match;
  } out_word_t;

  // the unused mode code falls back to 32-bit
  function automatic logic [CrcW-1:0] sel_poly(input logic [1:0] mode);
    logic [CrcW-1:0] poly;
    unique case (mode)
      WIDTH_16: poly = POLY_W16;
      WIDTH_5:  poly = POLY_W5;
      default:  poly = POLY_W32;
    endcase
    return poly;
  endfunction

  function automatic logic [CrcW-1:0] sel_mask(input logic [1:0] mode);
    logic [CrcW-1:0] mask;
    unique case (mode)
      WIDTH_16: mask = MASK_W16;
      WIDTH_5:  mask = MASK_W5;
      default:  mask = MASK_W32;
    endcase
    return mask;
  endfunction

endpackage

// ===== sv/brc_fold.sv =====
// ----------------------------------------------------------------------------
// brc_fold: one-byte crc update
// Folds a byte into the crc with eight unrolled shift/xor steps.
// ----------------------------------------------------------------------------
module brc_fold import brc_pkg::*; (
  input  logic [CrcW-1:0] crc,
  input  logic [7:0]      data_byte,
  input  logic [1:0]      width_mode,
  output logic [CrcW-1:0] crc_next
);

  logic [CrcW-1:0] poly;

  assign poly = sel_poly(width_mode);

  always_comb begin
    logic [CrcW-1:0] acc;
    acc = crc ^ {{(CrcW-8){1'b0}}, data_byte};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ poly;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_next = acc;
  end

endmodule

// ===== sv/bytewise_reflected_crc.sv =====
// ----------------------------------------------------------------------------
// bytewise_reflected_crc: byte-serial reflected crc, 32/16/5-bit width modes
// Input register, eight-step fold, result register on the last byte.
// ----------------------------------------------------------------------------
// a last byte passes the input register, then the result register, to its result word
// throughput: 1 byte per cycle, set by the single fold between input register
//   and crc register; stalls only while a result word waits at the output
// reset: synchronous, clears both stages, mode = 32-bit, crc = all ones
// a config write reloads the crc with the new mode's mask
module bytewise_reflected_crc import brc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  // byte stream
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  // result words
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data,
  // width mode register
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  logic [1:0]      width_mode;
  logic [CrcW-1:0] running_crc;

  // input stage
  in_word_t in_q;
  logic     in_q_valid;

  // result stage
  out_word_t out_q;
  logic      out_q_valid;

  logic            advance;
  logic [CrcW-1:0] folded;
  logic [CrcW-1:0] mask;
  logic [CrcW-1:0] result;

  // a non-last byte never needs the result register, so only a last byte
  // can be held back by a waiting result word
  assign advance   = in_q_valid && (!in_q.last_byte || !out_q_valid || out_ready);
  assign in_ready  = !in_q_valid || advance;
  assign cfg_ready = 1'b1;

  assign out_valid = out_q_valid;
  assign out_data  = out_q;

  brc_fold u_fold (
    .crc        (running_crc),
    .data_byte  (in_q.data_byte),
    .width_mode (width_mode),
    .crc_next   (folded)
  );

  assign mask   = sel_mask(width_mode);
  assign result = folded ^ mask;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      width_mode  <= WIDTH_32;
      running_crc <= MASK_W32;
      in_q_valid  <= 1'b0;
      out_q_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_q_valid <= in_valid;
      end
      if (out_q_valid && out_ready) begin
        out_q_valid <= 1'b0;
      end
      if (advance && in_q.last_byte) begin
        out_q_valid <= 1'b1;
      end
      // mode write abandons the message in progress
      if (cfg_valid) begin
        width_mode  <= cfg_data;
        running_crc <= sel_mask(cfg_data);
      end else if (advance) begin
        // last byte reloads the mask for the next message
        running_crc <= in_q.last_byte ? mask : folded;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
    if (advance && in_q.last_byte) begin
      out_q.crc_value <= result;
      out_q.crc_match <= (result == in_q.expected_crc);
    end
  end

endmodule

// ===== sv/brc_checker.sv =====
// ----------------------------------------------------------------------------
// brc_checker: port-level checks for the bytewise reflected crc
// Watches the handshakes over time and binds to the top level.
// ----------------------------------------------------------------------------
module brc_checker import brc_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a result word holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // reset empties the result stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

  // a new result word must trace back to a last byte taken at the input
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_byte, 2))
    else $error("result word without a last byte");

  // with an empty output the byte side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind bytewise_reflected_crc brc_checker u_brc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
